/* hw/rtl/bir_pkg.sv */
// Shared types, constants and helper functions for the bilinear image resizer.
// Used by every module under hw/rtl; depends on nothing else.
package bir_pkg;

    // Field and register widths
    localparam int COORD_W        = 12;
    localparam int SRC_DIM_W      = 9;
    localparam int DST_DIM_W      = 13;
    localparam int PIX_W          = 8;
    localparam int FRAC_BITS      = 8;
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int X_W            = $clog2(MAX_SRC_WIDTH);
    localparam int Y_W            = $clog2(MAX_SRC_HEIGHT);
    localparam int ADDR_W         = X_W + Y_W;
    localparam int DEPTH          = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int PROD_W         = COORD_W + SRC_DIM_W;
    localparam int NUM_W          = PROD_W + FRAC_BITS;
    localparam int QUOT_W         = X_W + FRAC_BITS;
    localparam int CNT_W          = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = DST_DIM_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    // Command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   red_in;
        logic [PIX_W-1:0]   green_in;
        logic [PIX_W-1:0]   blue_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             edge_copy;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic       div_start;
        logic       div_sel_y;
        logic       rd_en;
        logic [1:0] rd_idx;
        logic       blend_h;
        logic       out_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic compute_ok;
        logic div_done;
        logic out_full;
    } dp_status_t;

    // Weighted blend of two channel values, truncated to a pixel.
    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0]         w;
        logic [PIX_W+FRAC_BITS:0]   s;
        w = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
        s = (PIX_W+FRAC_BITS+1)'(a) * (PIX_W+FRAC_BITS+1)'(w)
          + (PIX_W+FRAC_BITS+1)'(b) * (PIX_W+FRAC_BITS+1)'(f);
        return s[FRAC_BITS +: PIX_W];
    endfunction

endpackage

/* hw/rtl/bir_div.sv */
// Restoring divider, one quotient bit per cycle, for the source position.
// Depends on bir_pkg for widths.
module bir_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bir_pkg::NUM_W-1:0]     num,
    input  logic [bir_pkg::DST_DIM_W-1:0] den,
    output logic                          done,
    output logic [bir_pkg::QUOT_W-1:0]    quot
);

    logic [bir_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [bir_pkg::DST_DIM_W-1:0] den_reg, den_next;
    logic [bir_pkg::DST_DIM_W-1:0] rem_reg, rem_next;
    logic [bir_pkg::QUOT_W-1:0]    quot_reg, quot_next;
    logic [bir_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [bir_pkg::DST_DIM_W:0]   trial;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[bir_pkg::NUM_W-1]};
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[bir_pkg::NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = bir_pkg::DST_DIM_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[bir_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[bir_pkg::DST_DIM_W-1:0];
                quot_next = {quot_reg[bir_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bir_pkg::CNT_W'(bir_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hw/rtl/bir_ctrl.sv */
// Controller state machine: sequences multiply, divide, fetch and blend.
// Depends on bir_pkg for the command and status structs.
module bir_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   req_command,
    input  bir_pkg::dp_status_t    status,
    output bir_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_SETX  = 10'b0000000100,
        ST_WAITX = 10'b0000001000,
        ST_SETY  = 10'b0000010000,
        ST_WAITY = 10'b0000100000,
        ST_READ  = 10'b0001000000,
        ST_RLAST = 10'b0010000000,
        ST_BH    = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd         = '0;
        cmd.accept  = accept;
        cmd.rd_idx  = rd_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_cnt_next = '0;
                if (accept && req_command == bir_pkg::CMD_COMPUTE && status.compute_ok)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SETX;
            end
            ST_SETX:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAITX;
            end
            ST_WAITX:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SETY;
                end
            end
            ST_SETY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = ST_WAITY;
            end
            ST_WAITY:
            begin
                cmd.div_sel_y = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en   = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = ST_RLAST;
                end
            end
            ST_RLAST:
            begin
                state_next = ST_BH;
            end
            ST_BH:
            begin
                cmd.blend_h = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // A divider result only arrives while the controller waits for it.
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_WAITX || state_reg == ST_WAITY))
        else $error("divider finished outside a wait state");

    // A result is never loaded over one that is still held.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_full)
        else $error("result loaded into a full output register");

    // An accepted in-range compute starts the multiply next cycle.
    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_command == bir_pkg::CMD_COMPUTE && status.compute_ok)
        |=> state_reg == ST_MUL)
        else $error("compute beat did not start the multiply");

endmodule

/* hw/rtl/bir_dp.sv */
// Datapath: configuration registers, frame store, scaling arithmetic,
// neighbor capture, blending and the output register.
// Depends on bir_pkg and bir_div.
module bir_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  bir_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output bir_pkg::rsp_t                    rsp,
    input  bir_pkg::ctrl_cmd_t               cmd,
    output bir_pkg::dp_status_t              status
);

    localparam int PW = bir_pkg::PIX_W;
    localparam int FB = bir_pkg::FRAC_BITS;

    logic [bir_pkg::SRC_DIM_W-1:0] sw_reg, sh_reg, sw_eff, sh_eff;
    logic [bir_pkg::DST_DIM_W-1:0] dw_reg, dh_reg, dw_eff, dh_eff;

    logic [bir_pkg::COORD_W-1:0]   row_reg, col_reg;
    logic [bir_pkg::PROD_W-1:0]    nx_reg, ny_reg;
    logic [bir_pkg::X_W-1:0]       xi_reg, xi_p1;
    logic [bir_pkg::Y_W-1:0]       yi_reg, yi_p1;
    logic [FB-1:0]                 fx_reg, fy_reg, fx_use, fy_use;
    logic                          edge_flag;

    logic [bir_pkg::NUM_W-1:0]     div_num;
    logic [bir_pkg::DST_DIM_W-1:0] div_den;
    logic                          div_done;
    logic [bir_pkg::QUOT_W-1:0]    div_quot;

    logic [3*PW-1:0]               mem [bir_pkg::DEPTH];
    logic [3*PW-1:0]               rdata_reg;
    logic [bir_pkg::ADDR_W-1:0]    mem_addr, rd_addr;
    logic                          load_we;
    logic                          rd_pend_reg;
    logic [1:0]                    rd_idx_q_reg;
    logic [3*PW-1:0]               pix_reg [4];
    logic [PW-1:0]                 top_reg [3];
    logic [PW-1:0]                 bot_reg [3];

    logic                          out_valid_reg, out_valid_next;
    bir_pkg::rsp_t                 rsp_reg;

    // Configuration registers and their effective values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= bir_pkg::SRC_DIM_W'(256);
            sh_reg <= bir_pkg::SRC_DIM_W'(256);
            dw_reg <= bir_pkg::DST_DIM_W'(256);
            dh_reg <= bir_pkg::DST_DIM_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bir_pkg::CFG_SRC_WIDTH:  sw_reg <= cfg_data[bir_pkg::SRC_DIM_W-1:0];
                bir_pkg::CFG_SRC_HEIGHT: sh_reg <= cfg_data[bir_pkg::SRC_DIM_W-1:0];
                bir_pkg::CFG_DST_WIDTH:  dw_reg <= cfg_data;
                bir_pkg::CFG_DST_HEIGHT: dh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sw_eff = sw_reg;
        if (sw_reg == '0)
            sw_eff = bir_pkg::SRC_DIM_W'(1);
        else if (sw_reg > bir_pkg::SRC_DIM_W'(bir_pkg::MAX_SRC_WIDTH))
            sw_eff = bir_pkg::SRC_DIM_W'(bir_pkg::MAX_SRC_WIDTH);
        sh_eff = sh_reg;
        if (sh_reg == '0)
            sh_eff = bir_pkg::SRC_DIM_W'(1);
        else if (sh_reg > bir_pkg::SRC_DIM_W'(bir_pkg::MAX_SRC_HEIGHT))
            sh_eff = bir_pkg::SRC_DIM_W'(bir_pkg::MAX_SRC_HEIGHT);
        dw_eff = (dw_reg == '0) ? bir_pkg::DST_DIM_W'(1) : dw_reg;
        dh_eff = (dh_reg == '0) ? bir_pkg::DST_DIM_W'(1) : dh_reg;
    end

    // Range checks on the incoming beat.
    assign status.compute_ok = ({1'b0, req.row} < dh_eff) && ({1'b0, req.col} < dw_eff);
    assign load_we = cmd.accept && (req.command == bir_pkg::CMD_LOAD)
                  && (bir_pkg::SRC_DIM_W'(req.row) < sh_eff)
                  && (bir_pkg::SRC_DIM_W'(req.col) < sw_eff)
                  && (req.row < bir_pkg::COORD_W'(bir_pkg::MAX_SRC_HEIGHT))
                  && (req.col < bir_pkg::COORD_W'(bir_pkg::MAX_SRC_WIDTH));

    // Latch the destination coordinates and scale them by the source size.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= req.row;
            col_reg <= req.col;
        end
        if (cmd.mul_en)
        begin
            nx_reg <= bir_pkg::PROD_W'(col_reg) * bir_pkg::PROD_W'(sw_eff);
            ny_reg <= bir_pkg::PROD_W'(row_reg) * bir_pkg::PROD_W'(sh_eff);
        end
    end

    // Shared divider for both axes: quotient holds integer part and fraction.
    assign div_num = cmd.div_sel_y ? {ny_reg, FB'(0)} : {nx_reg, FB'(0)};
    assign div_den = cmd.div_sel_y ? dh_eff : dw_eff;

    bir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign status.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (div_done && !cmd.div_sel_y)
        begin
            xi_reg <= div_quot[FB +: bir_pkg::X_W];
            fx_reg <= div_quot[FB-1:0];
        end
        if (div_done && cmd.div_sel_y)
        begin
            yi_reg <= div_quot[FB +: bir_pkg::Y_W];
            fy_reg <= div_quot[FB-1:0];
        end
    end

    // Edge case: the top-left pixel is copied and the weights are forced to zero.
    assign edge_flag = !(({1'b0, xi_reg} + 1'b1 < sw_eff) && ({1'b0, yi_reg} + 1'b1 < sh_eff));
    assign fx_use    = edge_flag ? '0 : fx_reg;
    assign fy_use    = edge_flag ? '0 : fy_reg;
    assign xi_p1     = xi_reg + 1'b1;
    assign yi_p1     = yi_reg + 1'b1;

    // Neighbor address for the current fetch step.
    always_comb
    begin
        case (cmd.rd_idx)
            2'd0:    rd_addr = {yi_reg, xi_reg};
            2'd1:    rd_addr = {yi_reg, xi_p1};
            2'd2:    rd_addr = {yi_p1, xi_reg};
            2'd3:    rd_addr = {yi_p1, xi_p1};
            default: rd_addr = {yi_reg, xi_reg};
        endcase
    end

    assign mem_addr = load_we ? {req.row[bir_pkg::Y_W-1:0], req.col[bir_pkg::X_W-1:0]}
                              : rd_addr;

    // Frame store, single port with registered read data.
    always_ff @(posedge clk)
    begin
        if (load_we)
            mem[mem_addr] <= {req.blue_in, req.green_in, req.red_in};
        if (cmd.rd_en)
            rdata_reg <= mem[mem_addr];
    end

    // Capture each neighbor from the registered read data into its pix_reg slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= cmd.rd_en;
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q_reg <= cmd.rd_idx;
        if (rd_pend_reg)
            pix_reg[rd_idx_q_reg] <= rdata_reg;
    end

    // Horizontal blend on the upper and lower pairs. At the frame edge only the
    // top-left pixel is meaningful, so it is passed on to both rows.
    always_ff @(posedge clk)
    begin
        if (cmd.blend_h)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (edge_flag)
                begin
                    top_reg[k] <= pix_reg[0][PW*k +: PW];
                    bot_reg[k] <= pix_reg[0][PW*k +: PW];
                end
                else
                begin
                    top_reg[k] <= bir_pkg::blend(pix_reg[0][PW*k +: PW],
                                                 pix_reg[1][PW*k +: PW], fx_use);
                    bot_reg[k] <= bir_pkg::blend(pix_reg[2][PW*k +: PW],
                                                 pix_reg[3][PW*k +: PW], fx_use);
                end
            end
        end
    end

    // Vertical blend straight into the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.red_out   <= bir_pkg::blend(top_reg[0], bot_reg[0], fy_use);
            rsp_reg.green_out <= bir_pkg::blend(top_reg[1], bot_reg[1], fy_use);
            rsp_reg.blue_out  <= bir_pkg::blend(top_reg[2], bot_reg[2], fy_use);
            rsp_reg.edge_copy <= edge_flag;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.out_full = out_valid_reg && !rsp_ready;
    assign rsp_valid       = out_valid_reg;
    assign rsp             = rsp_reg;

endmodule

/* hw/rtl/bilinear_image_resizer.sv */
// Top level of the bilinear image resizer: controller plus datapath.
// Depends on bir_pkg, bir_ctrl, bir_dp and bir_div.
//
// Usage: the req channel carries one beat per item (valid/ready). A load beat
// writes one source pixel into the frame store in the cycle it is accepted and
// gives no result; loads outside the source frame are dropped. A compute beat
// asks for one destination pixel and gives one beat on the rsp channel, unless
// its row or column lies outside the destination size, in which case it is
// dropped. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// once and must only happen while the block is idle.
// Sequence: a compute runs from accept to rsp_valid through one multiply,
// two passes of a 29-step serial divider (one quotient bit a cycle, shared
// by both axes), four reads on the single frame store port, and the
// horizontal and vertical blends. The block holds one compute at a time;
// the next beat is accepted once the result sits in the output register.
// Reset clears the control state and sets all size registers to 256; the
// frame store is not cleared and must be written before it is read.
// A stalled receiver holds the result in the output register; a finished
// compute then waits in ST_OUT before the block takes a new beat.
module bilinear_image_resizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  bir_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bir_pkg::rsp_t                  rsp
);

    bir_pkg::ctrl_cmd_t  cmd;
    bir_pkg::dp_status_t status;

    bir_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req.command),
        .status      (status),
        .cmd         (cmd)
    );

    bir_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the bilinear image resizer: random and directed
// load and compute beats, checked against a bit-accurate pixel predictor.
// Depends on bir_pkg and the bilinear_image_resizer top level.
module tb_top;

    // Predicts destination pixels from the loaded frame and the size registers.
    class resize_scoreboard;
        logic [23:0]          frame [int];
        int unsigned          src_w, src_h, dst_w, dst_h;
        bir_pkg::rsp_t        pending_px [$];
        int                   errors;

        function new();
            src_w = 256;
            src_h = 256;
            dst_w = 256;
            dst_h = 256;
            errors = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned eff_src_w();
            return clamp_dim(src_w, bir_pkg::MAX_SRC_WIDTH);
        endfunction

        function int unsigned eff_src_h();
            return clamp_dim(src_h, bir_pkg::MAX_SRC_HEIGHT);
        endfunction

        function void set_reg(logic [bir_pkg::CFG_IDX_W-1:0] idx,
                              logic [bir_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                bir_pkg::CFG_SRC_WIDTH:  src_w = v[bir_pkg::SRC_DIM_W-1:0];
                bir_pkg::CFG_SRC_HEIGHT: src_h = v[bir_pkg::SRC_DIM_W-1:0];
                bir_pkg::CFG_DST_WIDTH:  dst_w = v;
                default:                 dst_h = v;
            endcase
        endfunction

        // Source position of a destination pixel; returns 0 when it is dropped.
        function bit locate(int unsigned row, int unsigned col, output int unsigned xi,
                            output int unsigned yi, output int unsigned fx,
                            output int unsigned fy, output bit at_edge);
            int unsigned sw, sh, dw, dh, nx, ny;
            sw = eff_src_w();
            sh = eff_src_h();
            dw = clamp_dim(dst_w, 8191);
            dh = clamp_dim(dst_h, 8191);
            xi = 0; yi = 0; fx = 0; fy = 0; at_edge = 0;
            if (row >= dh || col >= dw)
                return 0;
            nx = col * sw;
            ny = row * sh;
            xi = nx / dw;
            yi = ny / dh;
            fx = ((nx % dw) << bir_pkg::FRAC_BITS) / dw;
            fy = ((ny % dh) << bir_pkg::FRAC_BITS) / dh;
            at_edge = !(xi + 1 < sw && yi + 1 < sh);
            return 1;
        endfunction

        // Store addresses whose pixels a compute at this position uses.
        function bit neighbors(int unsigned row, int unsigned col,
                               output int unsigned addrs[$]);
            int unsigned xi, yi, fx, fy;
            bit at_edge;
            addrs = {};
            if (!locate(row, col, xi, yi, fx, fy, at_edge))
                return 0;
            addrs.push_back(yi * bir_pkg::MAX_SRC_WIDTH + xi);
            if (!at_edge)
            begin
                addrs.push_back(yi * bir_pkg::MAX_SRC_WIDTH + xi + 1);
                addrs.push_back((yi + 1) * bir_pkg::MAX_SRC_WIDTH + xi);
                addrs.push_back((yi + 1) * bir_pkg::MAX_SRC_WIDTH + xi + 1);
            end
            return 1;
        endfunction

        function logic [23:0] pixel_at(int unsigned a);
            return frame.exists(a) ? frame[a] : 24'd0;
        endfunction

        function int unsigned mix(int unsigned a, int unsigned b, int unsigned f);
            return ((a * ((1 << bir_pkg::FRAC_BITS) - f) + b * f) >> bir_pkg::FRAC_BITS)
                   & 8'hFF;
        endfunction

        // Channel k of a stored pixel: 0 red, 1 green, 2 blue.
        function int unsigned chan(logic [23:0] p, int k);
            return (p >> (8 * k)) & 8'hFF;
        endfunction

        function void note_input(bir_pkg::req_t r);
            int unsigned xi, yi, fx, fy, v [3];
            logic [23:0] p11, p12, p21, p22;
            bit at_edge;
            bir_pkg::rsp_t px;
            if (r.command == bir_pkg::CMD_LOAD)
            begin
                if (r.row < eff_src_h() && r.col < eff_src_w())
                    frame[r.row * bir_pkg::MAX_SRC_WIDTH + r.col] =
                        {r.blue_in, r.green_in, r.red_in};
                return;
            end
            if (!locate(r.row, r.col, xi, yi, fx, fy, at_edge))
                return;
            p11 = pixel_at(yi * bir_pkg::MAX_SRC_WIDTH + xi);
            if (at_edge)
            begin
                for (int k = 0; k < 3; k++)
                    v[k] = chan(p11, k);
            end
            else
            begin
                p12 = pixel_at(yi * bir_pkg::MAX_SRC_WIDTH + xi + 1);
                p21 = pixel_at((yi + 1) * bir_pkg::MAX_SRC_WIDTH + xi);
                p22 = pixel_at((yi + 1) * bir_pkg::MAX_SRC_WIDTH + xi + 1);
                for (int k = 0; k < 3; k++)
                    v[k] = mix(mix(chan(p11, k), chan(p12, k), fx),
                               mix(chan(p21, k), chan(p22, k), fx), fy);
            end
            px.red_out   = bir_pkg::PIX_W'(v[0]);
            px.green_out = bir_pkg::PIX_W'(v[1]);
            px.blue_out  = bir_pkg::PIX_W'(v[2]);
            px.edge_copy = at_edge;
            pending_px.push_back(px);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(bir_pkg::rsp_t got);
            bir_pkg::rsp_t want;
            if (pending_px.size() == 0)
            begin
                report($sformatf("unexpected result beat %p", got));
                return;
            end
            want = pending_px.pop_front();
            if (got.red_out !== want.red_out)
                report($sformatf("red got %0d want %0d", got.red_out, want.red_out));
            if (got.green_out !== want.green_out)
                report($sformatf("green got %0d want %0d", got.green_out, want.green_out));
            if (got.blue_out !== want.blue_out)
                report($sformatf("blue got %0d want %0d", got.blue_out, want.blue_out));
            if (got.edge_copy !== want.edge_copy)
                report($sformatf("edge_copy got %0d want %0d", got.edge_copy, want.edge_copy));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bir_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           req_valid;
    logic                           req_ready;
    bir_pkg::req_t                  req_beat;
    logic                           rsp_valid;
    logic                           rsp_ready;
    bir_pkg::rsp_t                  rsp_beat;

    resize_scoreboard sb = new();
    bit               no_idle;
    int               results_seen;
    int               hold_cycles;
    bit               hold_done;

    bilinear_image_resizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_beat)
    );

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, one long hold-off, and the check of each beat.
    initial
    begin
        rsp_ready = 0;
        results_seen = 0;
        hold_cycles = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                sb.check_result(rsp_beat);
                results_seen++;
            end
            if (!hold_done && results_seen == 150)
            begin
                hold_done = 1;
                hold_cycles = 500;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ready <= 0;
            end
            else
                rsp_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // Offers one beat and waits until it is accepted.
    task automatic send(bir_pkg::req_t r);
        if (!no_idle && $urandom_range(99) < 38)
        begin
            req_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1;
        req_beat <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_input(r);
    endtask

    task automatic load_px(int unsigned row, int unsigned col, logic [23:0] px);
        bir_pkg::req_t r;
        r.command  = bir_pkg::CMD_LOAD;
        r.row      = bir_pkg::COORD_W'(row);
        r.col      = bir_pkg::COORD_W'(col);
        r.red_in   = px[7:0];
        r.green_in = px[15:8];
        r.blue_in  = px[23:16];
        send(r);
    endtask

    // Loads any neighbor not yet written, then asks for the destination pixel.
    task automatic compute_px(int unsigned row, int unsigned col);
        int unsigned need [$];
        bir_pkg::req_t r;
        if (sb.neighbors(row, col, need))
            foreach (need[i])
                if (!sb.frame.exists(need[i]))
                    load_px(need[i] / bir_pkg::MAX_SRC_WIDTH,
                            need[i] % bir_pkg::MAX_SRC_WIDTH, 24'($urandom));
        r = bir_pkg::req_t'({$urandom, $urandom});
        r.command = bir_pkg::CMD_COMPUTE;
        r.row = bir_pkg::COORD_W'(row);
        r.col = bir_pkg::COORD_W'(col);
        send(r);
    endtask

    // Writes all four size registers once the block has drained.
    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh);
        logic [bir_pkg::CFG_DATA_W-1:0] vals [4];
        logic [bir_pkg::CFG_IDX_W-1:0]  idx [4];
        req_valid <= 0;
        while (sb.pending_px.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        vals = '{bir_pkg::CFG_DATA_W'(sw), bir_pkg::CFG_DATA_W'(sh),
                 bir_pkg::CFG_DATA_W'(dw), bir_pkg::CFG_DATA_W'(dh)};
        idx = '{bir_pkg::CFG_SRC_WIDTH, bir_pkg::CFG_SRC_HEIGHT,
                bir_pkg::CFG_DST_WIDTH, bir_pkg::CFG_DST_HEIGHT};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_we <= 0;
    endtask

    // Mostly well-formed computes and in-frame loads, with some raw noise.
    task automatic random_items(int n);
        int unsigned pick, dw, dh;
        bir_pkg::req_t r;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            dw = (sb.dst_w == 0) ? 1 : ((sb.dst_w > 4096) ? 4096 : sb.dst_w);
            dh = (sb.dst_h == 0) ? 1 : ((sb.dst_h > 4096) ? 4096 : sb.dst_h);
            if (pick < 55)
                compute_px($urandom_range(dh - 1), $urandom_range(dw - 1));
            else if (pick < 70)
                compute_px($urandom_range(4095), $urandom_range(4095));
            else if (pick < 92)
                load_px($urandom_range(sb.eff_src_h() - 1), $urandom_range(sb.eff_src_w() - 1),
                        24'($urandom));
            else
            begin
                r = bir_pkg::req_t'({$urandom, $urandom});
                r.command = bir_pkg::CMD_LOAD;
                send(r);
            end
        end
    endtask

    // Stimulus: reset, directed beats, then a series of size settings.
    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = bir_pkg::CFG_SRC_WIDTH;
        cfg_data = 0;
        req_valid = 0;
        req_beat = '0;
        no_idle = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Small frame: fill it, hit corners, edges and dropped beats.
        set_sizes(4, 3, 9, 7);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                load_px(y, x, ((x + y) % 2 == 0) ? 24'hFFFFFF : 24'h000000);
        load_px(4095, 4095, 24'hFFFFFF);
        load_px(2, 3, 24'h00FF80);
        compute_px(0, 0);
        compute_px(3, 4);
        compute_px(6, 8);
        compute_px(2, 8);
        compute_px(7, 0);
        compute_px(0, 9);
        compute_px(4095, 4095);
        random_items(60);

        set_sizes(256, 256, 256, 256);
        random_items(65);
        no_idle = 1;
        set_sizes(1, 1, 1, 1);
        random_items(65);
        no_idle = 0;
        set_sizes(0, 0, 0, 0);
        random_items(65);
        set_sizes(511, 300, 4096, 8191);
        random_items(65);
        set_sizes(256, 256, 13, 5);
        random_items(65);
        set_sizes(2, 2, 8191, 4096);
        random_items(65);
        set_sizes(17, 9, 40, 33);
        random_items(65);
        set_sizes(200, 150, 100, 400);
        random_items(65);
        set_sizes($urandom_range(1, 256), $urandom_range(1, 256),
                  $urandom_range(1, 300), $urandom_range(1, 300));
        random_items(65);

        req_valid <= 0;
        while (sb.pending_px.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #15000000;
        $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/bir_pkg.sv
hw/rtl/bir_div.sv
hw/rtl/bir_ctrl.sv
hw/rtl/bir_dp.sv
hw/rtl/bilinear_image_resizer.sv
verif/tb_top.sv
